@@ sv/deq_pkg.sv @@
// Package for the double-ended queue: request codes, cell commands, status codes
// and field widths. Used by deq_cell, deq_chain and double_ended_queue_unit.
// It has no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

    // Field widths
    localparam int WORD_W = 32;
    localparam int FUNC_W = 3;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 6;

    // Request codes
    localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd0;
    localparam logic [FUNC_W-1:0] FN_PUSH_REAR  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_POP_REAR   = 3'd3;
    localparam logic [FUNC_W-1:0] FN_PEEK_FRONT = 3'd4;
    localparam logic [FUNC_W-1:0] FN_PEEK_REAR  = 3'd5;
    localparam logic [FUNC_W-1:0] FN_DUMP       = 3'd6;
    localparam logic [FUNC_W-1:0] FN_CLEAR      = 3'd7;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // Commands broadcast to every cell of the chain
    localparam int CMD_W = 3;
    localparam logic [CMD_W-1:0] CELL_HOLD = 3'd0;  // keep the word
    localparam logic [CMD_W-1:0] CELL_SHR  = 3'd1;  // take left neighbor (push front)
    localparam logic [CMD_W-1:0] CELL_SHL  = 3'd2;  // take right neighbor (pop front)
    localparam logic [CMD_W-1:0] CELL_ROT  = 3'd3;  // rotate occupied cells by one
    localparam logic [CMD_W-1:0] CELL_PUT  = 3'd4;  // write at the first free cell

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [WORD_W-1:0] wdata;
    } cell_ctl_t;

endpackage

`default_nettype wire

@@ sv/deq_cell.sv @@
// One storage cell of the deque chain: holds one word and loads it from a
// neighbor, the front cell or the push data. Depends on deq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module deq_cell #(
    parameter int IDX = 0,
    parameter int CW  = 6
) (
    input  wire                       aclk,
    input  wire deq_pkg::cell_ctl_t   ctl,
    input  wire [CW-1:0]              count,
    input  wire [deq_pkg::WORD_W-1:0] left_word,
    input  wire [deq_pkg::WORD_W-1:0] right_word,
    input  wire [deq_pkg::WORD_W-1:0] front_word,
    output wire [deq_pkg::WORD_W-1:0] word_q,
    output wire [deq_pkg::WORD_W-1:0] rear_part
);
    import deq_pkg::*;

    localparam logic [CW-1:0] MY_IDX   = CW'(IDX);
    localparam logic [CW-1:0] NEXT_IDX = CW'(IDX + 1);

    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;

    // Next word per broadcast command
    always_comb begin
        word_next = word_reg;
        case (ctl.cmd)
            CELL_SHR: word_next = left_word;
            CELL_SHL: word_next = right_word;
            CELL_ROT: word_next = (NEXT_IDX < count) ? right_word : front_word;
            CELL_PUT: begin
                if (count == MY_IDX) begin
                    word_next = ctl.wdata;
                end
            end
            default: word_next = word_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    assign word_q    = word_reg;
    // This cell is the rear entry when it is the last occupied one
    assign rear_part = (count == NEXT_IDX) ? word_reg : '0;

endmodule

`default_nettype wire

@@ sv/deq_chain.sv @@
// Row of deq_cell instances forming the deque storage; front is cell 0.
// Provides the front word and the rear word. Depends on deq_pkg and deq_cell.
`timescale 1ns / 1ps
`default_nettype none

module deq_chain #(
    parameter int DEPTH = 32,
    parameter int CW    = 6
) (
    input  wire                       aclk,
    input  wire deq_pkg::cell_ctl_t   ctl,
    input  wire [CW-1:0]              count,
    output logic [deq_pkg::WORD_W-1:0] front_word,
    output logic [deq_pkg::WORD_W-1:0] rear_word
);
    import deq_pkg::*;

    logic [WORD_W-1:0] words [DEPTH];
    logic [WORD_W-1:0] rears [DEPTH];

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic [WORD_W-1:0] left_w;
            logic [WORD_W-1:0] right_w;

            if (gi == 0) begin : g_first
                assign left_w = ctl.wdata;
            end else begin : g_mid_l
                assign left_w = words[gi-1];
            end

            if (gi == DEPTH - 1) begin : g_last
                assign right_w = '0;
            end else begin : g_mid_r
                assign right_w = words[gi+1];
            end

            deq_cell #(
                .IDX (gi),
                .CW  (CW)
            ) u_cell (
                .aclk       (aclk),
                .ctl        (ctl),
                .count      (count),
                .left_word  (left_w),
                .right_word (right_w),
                .front_word (words[0]),
                .word_q     (words[gi]),
                .rear_part  (rears[gi])
            );
        end
    endgenerate

    assign front_word = words[0];

    // At most one cell is the rear; combine the per-cell selections
    always_comb begin
        rear_word = '0;
        for (int i = 0; i < DEPTH; i++) begin
            rear_word = rear_word | rears[i];
        end
    end

endmodule

`default_nettype wire

@@ sv/double_ended_queue_unit.sv @@
// Double-ended queue top level: request decode, occupancy count, dump
// sequencer and registered result item. Depends on deq_pkg and deq_chain.
// The result of a request is registered and shown on m_* in the cycle after it is accepted.
// Throughput: one request per cycle for push, pop, peek and clear unless m_* stalls;
// a dump gives one item per entry, per cycle unless m_* stalls, rotating by one cell.
// Reset: aresetn (synchronous, active low) empties the queue; stored words are kept.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue_unit #(
    parameter int DEPTH = 32
) (
    input  wire         aclk,
    input  wire         aresetn,
    // s_tdata: func [2:0], push_value [34:3], zero pad [39:35]
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [39:0] s_tdata,
    // m_tdata: word_out [31:0], occupancy [37:32], zero pad [39:38]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [39:0] m_tdata,
    // m_tuser: status [1:0]
    output logic [1:0]  m_tuser,
    output logic        m_tlast
);
    import deq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_CNT  = CW'(1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DUMP = 1'b1;

    logic              state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     left_reg,  left_next;
    logic              m_valid_reg, m_valid_next;
    logic [WORD_W-1:0] word_reg,  word_next;
    logic [STAT_W-1:0] stat_reg,  stat_next;
    logic [OCC_W-1:0]  occ_reg,   occ_next;
    logic              last_reg,  last_next;

    cell_ctl_t         ctl;
    logic [WORD_W-1:0] front_word;
    logic [WORD_W-1:0] rear_word;
    logic              out_free;
    logic              fire_in;
    logic              load_out;
    logic [FUNC_W-1:0] func;
    logic [WORD_W-1:0] push_value;
    logic              is_empty;
    logic              is_full;

    assign func       = s_tdata[FUNC_W-1:0];
    assign push_value = s_tdata[FUNC_W +: WORD_W];
    assign out_free   = !m_valid_reg || m_tready;
    assign s_tready   = (state_reg == ST_IDLE) && out_free;
    assign fire_in    = s_tvalid && s_tready;
    assign is_empty   = (count_reg == '0);
    assign is_full    = (count_reg == FULL_CNT);

    deq_chain #(
        .DEPTH (DEPTH),
        .CW    (CW)
    ) u_chain (
        .aclk       (aclk),
        .ctl        (ctl),
        .count      (count_reg),
        .front_word (front_word),
        .rear_word  (rear_word)
    );

    // Request decode and dump sequencing
    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        left_next  = left_reg;
        ctl.cmd    = CELL_HOLD;
        ctl.wdata  = push_value;
        load_out   = 1'b0;
        word_next  = '0;
        stat_next  = ST_OK;
        last_next  = 1'b1;

        unique case (state_reg)
            ST_IDLE: begin
                if (fire_in) begin
                    load_out = 1'b1;
                    case (func)
                        FN_PUSH_FRONT, FN_PUSH_REAR: begin
                            if (is_full) begin
                                stat_next = ST_FULL;
                            end else begin
                                ctl.cmd    = (func == FN_PUSH_FRONT) ? CELL_SHR : CELL_PUT;
                                count_next = count_reg + ONE_CNT;
                            end
                        end
                        FN_POP_FRONT, FN_POP_REAR, FN_PEEK_FRONT, FN_PEEK_REAR: begin
                            if (is_empty) begin
                                stat_next = ST_EMPTY;
                            end else begin
                                word_next = (func == FN_POP_FRONT || func == FN_PEEK_FRONT)
                                            ? front_word : rear_word;
                                if (func == FN_POP_FRONT) begin
                                    ctl.cmd = CELL_SHL;
                                end
                                if (func == FN_POP_FRONT || func == FN_POP_REAR) begin
                                    count_next = count_reg - ONE_CNT;
                                end
                            end
                        end
                        FN_DUMP: begin
                            if (is_empty) begin
                                stat_next = ST_EMPTY;
                            end else begin
                                // first entry now, the rest from the dump state
                                word_next = front_word;
                                ctl.cmd   = CELL_ROT;
                                last_next = (count_reg == ONE_CNT);
                                left_next = count_reg - ONE_CNT;
                                if (count_reg != ONE_CNT) begin
                                    state_next = ST_DUMP;
                                end
                            end
                        end
                        default: begin
                            count_next = '0;
                        end
                    endcase
                end
            end
            ST_DUMP: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    word_next  = front_word;
                    ctl.cmd    = CELL_ROT;
                    last_next  = (left_reg == ONE_CNT);
                    left_next  = left_reg - ONE_CNT;
                    if (left_reg == ONE_CNT) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        occ_next     = OCC_W'(count_next);
        m_valid_next = load_out ? 1'b1 : (m_valid_reg && !m_tready);
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            left_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            left_reg    <= left_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Result item register
    always_ff @(posedge aclk) begin
        if (load_out) begin
            word_reg <= word_next;
            stat_reg <= stat_next;
            occ_reg  <= occ_next;
            last_reg <= last_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, occ_reg, word_reg};
    assign m_tuser  = stat_reg;
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire
